### sv/shake_detector_imu_defines.svh
// Assertion macros used by the shake detector top level.
`ifndef SHAKE_DETECTOR_IMU_DEFINES_SVH
`define SHAKE_DETECTOR_IMU_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SDI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shake detector check failed");
// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SDI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shake detector check failed");
`else
`define SDI_ASSERT_NOW(lbl, ante, cons)
`define SDI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### sv/sdi_pkg.sv
// Shared types, constants and helpers of the shake detector.
`timescale 1ns / 1ps
package sdi_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 32;
  localparam int unsigned REG_BITS        = 16;
  localparam int unsigned REG_IDX_BITS    = 3;
  localparam int unsigned FIELD_BITS      = 16;
  localparam int unsigned NOW_BITS        = 32;
  localparam int unsigned IN_DATA_BITS    = 6 * FIELD_BITS + NOW_BITS;
  localparam int unsigned OUT_DATA_BITS   = 40;

  // Register reset values.
  localparam logic [REG_BITS-1:0] GRAVITY_RST   = 16'd8192;
  localparam logic [REG_BITS-1:0] DEV_THR_RST   = 16'd4096;
  localparam logic [REG_BITS-1:0] CHG_THR_RST   = 16'd4096;
  localparam logic [REG_BITS-1:0] GYRO_THR_RST  = 16'd26200;
  localparam logic [REG_BITS-1:0] COOLDOWN_RST  = 16'd1000;

  // Register indexes on the configuration port.
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_GRAVITY  = 3'd0,
    REG_DEV_THR  = 3'd1,
    REG_CHG_THR  = 3'd2,
    REG_GYRO_THR = 3'd3,
    REG_COOLDOWN = 3'd4
  } cfg_reg_e;

  // Configuration register file.
  typedef struct packed {
    logic [REG_BITS-1:0] gravity_reference;
    logic [REG_BITS-1:0] accel_deviation_threshold;
    logic [REG_BITS-1:0] accel_change_threshold;
    logic [REG_BITS-1:0] gyro_threshold;
    logic [REG_BITS-1:0] cooldown_ms;
  } cfg_t;

  // Absolute difference of two register-wide unsigned values.
  function automatic logic [REG_BITS-1:0] absdiff(input logic [REG_BITS-1:0] a,
                                                  input logic [REG_BITS-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### sv/shake_detector_imu.sv
// Top level of the inertial shake detector: stream ports, registers, lanes and output stage.
`timescale 1ns / 1ps
`include "shake_detector_imu_defines.svh"
// Shake detector for one inertial sample per transaction. Two lanes run side by
// side, one forming the accelerometer magnitude and one the gyro magnitude, each
// as the floor square root of the sum of squares; a merge stage then applies the
// gravity deviation, sample-to-sample change and gyro thresholds and the
// millisecond cooldown. From acceptance to a valid result, each lane's single
// multiplier squares the three axes one after another, the bit-serial root
// recurrence then forms the magnitude, and the finished lanes hand off into the
// output register. One sample is in flight at a time; the next is taken in the
// cycle after the result has moved into the output register, even while that
// result still waits for the sink. The user must write the configuration
// registers only while no sample is in flight; the block does not enforce this.
module shake_detector_imu #(
  parameter int unsigned SAMPLE_BITS = sdi_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TIME_BITS   = sdi_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [sdi_pkg::REG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [sdi_pkg::REG_BITS-1:0]         cfg_data_i,
  // Sample stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_x[63:48],
  // gyro_y[79:64], gyro_z[95:80], now_ms[127:96]
  input  logic [sdi_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // shake[0], accel_magnitude[16:1], gyro_magnitude[32:17], zeros[39:33]
  output logic [sdi_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata
);

  localparam int unsigned FB = sdi_pkg::FIELD_BITS;

  sdi_pkg::cfg_t          cfg_q;
  logic                   busy_q;
  logic [TIME_BITS-1:0]   now_q;
  logic                   m_valid_q;
  logic                   m_shake_q;
  logic [FB-1:0]          m_amag_q;
  logic [FB-1:0]          m_gmag_q;

  logic                   in_fire;
  logic                   load;
  logic                   acc_done;
  logic                   gyr_done;
  logic [SAMPLE_BITS-1:0] acc_mag;
  logic [SAMPLE_BITS-1:0] gyr_mag;
  logic                   shake;

  assign s_axis_tready = !busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign load          = acc_done && gyr_done && (!m_valid_q || m_axis_tready);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity_reference         <= sdi_pkg::GRAVITY_RST;
      cfg_q.accel_deviation_threshold <= sdi_pkg::DEV_THR_RST;
      cfg_q.accel_change_threshold    <= sdi_pkg::CHG_THR_RST;
      cfg_q.gyro_threshold            <= sdi_pkg::GYRO_THR_RST;
      cfg_q.cooldown_ms               <= sdi_pkg::COOLDOWN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sdi_pkg::REG_GRAVITY:  cfg_q.gravity_reference         <= cfg_data_i;
        sdi_pkg::REG_DEV_THR:  cfg_q.accel_deviation_threshold <= cfg_data_i;
        sdi_pkg::REG_CHG_THR:  cfg_q.accel_change_threshold    <= cfg_data_i;
        sdi_pkg::REG_GYRO_THR: cfg_q.gyro_threshold            <= cfg_data_i;
        sdi_pkg::REG_COOLDOWN: cfg_q.cooldown_ms               <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Busy flag covers one sample from acceptance until its result is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_fire) begin
      busy_q <= 1'b1;
    end else if (load) begin
      busy_q <= 1'b0;
    end
  end

  // Timestamp of the sample in flight.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q <= s_axis_tdata[6*FB +: TIME_BITS];
    end
  end

  // Magnitude lanes.
  sdi_mag_lane #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_acc_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_fire),
    .x_i    (s_axis_tdata[0*FB +: SAMPLE_BITS]),
    .y_i    (s_axis_tdata[1*FB +: SAMPLE_BITS]),
    .z_i    (s_axis_tdata[2*FB +: SAMPLE_BITS]),
    .ack_i  (load),
    .done_o (acc_done),
    .mag_o  (acc_mag)
  );

  sdi_mag_lane #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_gyr_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_fire),
    .x_i    (s_axis_tdata[3*FB +: SAMPLE_BITS]),
    .y_i    (s_axis_tdata[4*FB +: SAMPLE_BITS]),
    .z_i    (s_axis_tdata[5*FB +: SAMPLE_BITS]),
    .ack_i  (load),
    .done_o (gyr_done),
    .mag_o  (gyr_mag)
  );

  // Merge stage.
  sdi_decide #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_decide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .amag_i (acc_mag),
    .gmag_i (gyr_mag),
    .now_i  (now_q),
    .load_i (load),
    .shake_o(shake)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_shake_q <= shake;
      m_amag_q  <= FB'(acc_mag);
      m_gmag_q  <= FB'(gyr_mag);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_gmag_q, m_amag_q, m_shake_q};

  // Checks.
  `SDI_ASSERT_NOW(a_lanes_in_step, acc_done || gyr_done, acc_done && gyr_done)
  `SDI_ASSERT_NOW(a_done_while_busy, acc_done, busy_q)
  `SDI_ASSERT_NEXT(a_load_shows_result, load, m_axis_tvalid)
  `SDI_ASSERT_NEXT(a_accept_blocks_next, in_fire, !s_axis_tready && !acc_done)

endmodule

### sv/sdi_mag_lane.sv
// One magnitude lane: sum of three squares, then a bit-serial integer square root.
`timescale 1ns / 1ps
module sdi_mag_lane #(
  parameter int unsigned SAMPLE_BITS = sdi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic signed [SAMPLE_BITS-1:0] y_i,
  input  logic signed [SAMPLE_BITS-1:0] z_i,
  input  logic                          ack_i,
  output logic                          done_o,
  output logic [SAMPLE_BITS-1:0]        mag_o
);

  localparam int unsigned SUM_BITS = 2 * SAMPLE_BITS;
  localparam int unsigned REM_BITS = SAMPLE_BITS + 2;
  localparam int unsigned CNT_BITS = $clog2(SAMPLE_BITS);
  localparam logic [CNT_BITS-1:0] LAST_AXIS = CNT_BITS'(2);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(SAMPLE_BITS - 1);

  typedef enum logic [1:0] {
    L_IDLE,
    L_SQUARE,
    L_ROOT,
    L_DONE
  } lane_state_e;

  lane_state_e               state_q;
  logic [CNT_BITS-1:0]       cnt_q;
  logic [SAMPLE_BITS-1:0]    abs_q [3];
  logic [SUM_BITS-1:0]       sum_q;
  logic [REM_BITS-1:0]       rem_q;
  logic [SAMPLE_BITS-1:0]    root_q;

  logic [SAMPLE_BITS-1:0]    abs_sel;
  logic [SUM_BITS-1:0]       square;
  logic [REM_BITS-1:0]       rem_shift;
  logic [REM_BITS-1:0]       trial;
  logic                      fits;

  // Two's complement magnitude of an axis; the most negative value maps to 2^(n-1).
  function automatic logic [SAMPLE_BITS-1:0] axis_abs(input logic signed [SAMPLE_BITS-1:0] v);
    return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
  endfunction

  // One multiplier squares one axis per cycle.
  assign abs_sel = abs_q[cnt_q[1:0]];
  assign square  = SUM_BITS'(abs_sel) * SUM_BITS'(abs_sel);

  // Restoring square root recurrence: one result bit per cycle.
  assign rem_shift = {rem_q[SAMPLE_BITS-1:0], sum_q[SUM_BITS-1 -: 2]};
  assign trial     = {root_q, 2'b01};
  assign fits      = (rem_shift >= trial);

  // Lane sequencer with its datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      abs_q   <= '{default: '0};
      sum_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
    end else begin
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            abs_q[0] <= axis_abs(x_i);
            abs_q[1] <= axis_abs(y_i);
            abs_q[2] <= axis_abs(z_i);
            sum_q    <= '0;
            cnt_q    <= '0;
            state_q  <= L_SQUARE;
          end
        end
        L_SQUARE: begin
          sum_q <= sum_q + square;
          if (cnt_q == LAST_AXIS) begin
            cnt_q   <= LAST_STEP;
            rem_q   <= '0;
            root_q  <= '0;
            state_q <= L_ROOT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        L_ROOT: begin
          sum_q <= {sum_q[SUM_BITS-3:0], 2'b00};
          if (fits) begin
            rem_q  <= rem_shift - trial;
            root_q <= {root_q[SAMPLE_BITS-2:0], 1'b1};
          end else begin
            rem_q  <= rem_shift;
            root_q <= {root_q[SAMPLE_BITS-2:0], 1'b0};
          end
          if (cnt_q == '0) begin
            state_q <= L_DONE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        L_DONE: begin
          if (ack_i) begin
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == L_DONE);
  assign mag_o  = root_q;

endmodule

### sv/sdi_decide.sv
// Merge stage: combines both lane magnitudes into the shake decision and keeps history.
`timescale 1ns / 1ps
module sdi_decide #(
  parameter int unsigned SAMPLE_BITS = sdi_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TIME_BITS   = sdi_pkg::TIME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sdi_pkg::cfg_t          cfg_i,
  input  logic [SAMPLE_BITS-1:0] amag_i,
  input  logic [SAMPLE_BITS-1:0] gmag_i,
  input  logic [TIME_BITS-1:0]   now_i,
  input  logic                   load_i,
  output logic                   shake_o
);

  logic [SAMPLE_BITS-1:0]       prev_mag_q;
  logic                         have_prev_q;
  logic [TIME_BITS-1:0]         last_shake_q;

  logic [sdi_pkg::REG_BITS-1:0] amag_w;
  logic [sdi_pkg::REG_BITS-1:0] gmag_w;
  logic [sdi_pkg::REG_BITS-1:0] deviation;
  logic [sdi_pkg::REG_BITS-1:0] change;
  logic [TIME_BITS-1:0]         elapsed;
  logic                         cool_ok;
  logic                         strong_accel;
  logic                         strong_gyro;

  assign amag_w = sdi_pkg::REG_BITS'(amag_i);
  assign gmag_w = sdi_pkg::REG_BITS'(gmag_i);

  // Accel deviation from gravity and change since the previous sample.
  assign deviation = sdi_pkg::absdiff(amag_w, cfg_i.gravity_reference);
  assign change    = have_prev_q ?
                     sdi_pkg::absdiff(amag_w, sdi_pkg::REG_BITS'(prev_mag_q)) : '0;

  assign strong_accel = (deviation > cfg_i.accel_deviation_threshold) ||
                        (change > cfg_i.accel_change_threshold);
  assign strong_gyro  = (gmag_w > cfg_i.gyro_threshold);

  // Wrapping elapsed time since the last shake gates the flag.
  assign elapsed = now_i - last_shake_q;
  assign cool_ok = (elapsed >= TIME_BITS'(cfg_i.cooldown_ms));
  assign shake_o = cool_ok && (strong_accel || strong_gyro);

  // History is updated once per sample as the result is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mag_q   <= '0;
      have_prev_q  <= 1'b0;
      last_shake_q <= '0;
    end else if (load_i) begin
      prev_mag_q  <= amag_i;
      have_prev_q <= 1'b1;
      if (shake_o) begin
        last_shake_q <= now_i;
      end
    end
  end

endmodule

### sim/tb_shake_detector_imu.sv
// Self-checking testbench of the inertial shake detector with a stream driver and monitor.
`timescale 1ns / 1ps
module tb_shake_detector_imu;

  localparam int unsigned REG_COUNT      = 5;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 50;
  localparam int unsigned RANDOM_PHASES  = 14;
  localparam int unsigned PHASE_SAMPLES  = 90;
  localparam int unsigned CALM_FIRST     = 12000;
  localparam int unsigned CALM_LAST      = 18000;
  localparam int unsigned TIMEOUT_NS     = 1000000;

  // Kinds of entries in the stimulus plan.
  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_CONFIG,
    OP_DRAIN
  } plan_kind_e;

  typedef struct packed {
    plan_kind_e                             kind;
    logic [sdi_pkg::REG_IDX_BITS-1:0]       index;
    logic [sdi_pkg::REG_BITS-1:0]           value;
    logic [sdi_pkg::IN_DATA_BITS-1:0]       payload;
  } plan_entry_t;

  typedef struct packed {
    logic                           shake;
    logic [sdi_pkg::FIELD_BITS-1:0] accel_mag;
    logic [sdi_pkg::FIELD_BITS-1:0] gyro_mag;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                              cfg_we = 1'b0;
  logic [sdi_pkg::REG_IDX_BITS-1:0]  cfg_index = '0;
  logic [sdi_pkg::REG_BITS-1:0]      cfg_data = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [sdi_pkg::IN_DATA_BITS-1:0]  s_tdata = '0;
  logic                              m_axis_tvalid;
  logic                              m_tready = 1'b0;
  logic [sdi_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;

  plan_entry_t sensor_plan[$];
  reading_t    predicted_readings[$];
  int unsigned samples_sent = 0;
  int unsigned readings_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;

  // Planning copies of the register values, used to shape random samples.
  int plan_gravity = sdi_pkg::GRAVITY_RST;
  int plan_dev     = sdi_pkg::DEV_THR_RST;
  int plan_chg     = sdi_pkg::CHG_THR_RST;
  int plan_gyro    = sdi_pkg::GYRO_THR_RST;
  int plan_cool    = sdi_pkg::COOLDOWN_RST;

  // Predictor state and register copy.
  sdi_pkg::cfg_t model_cfg = '{sdi_pkg::GRAVITY_RST, sdi_pkg::DEV_THR_RST,
                               sdi_pkg::CHG_THR_RST, sdi_pkg::GYRO_THR_RST,
                               sdi_pkg::COOLDOWN_RST};
  logic [sdi_pkg::FIELD_BITS-1:0] prev_accel_mag = '0;
  logic                           have_prev = 1'b0;
  logic [sdi_pkg::NOW_BITS-1:0]   last_shake_ms = '0;

  shake_detector_imu DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, now_ms from bit 0 up
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    // shake, accel_magnitude, gyro_magnitude, zero padding from bit 0 up
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Random idle decision, switched off during one calm window.
  function automatic logic pause_now();
    if (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST) begin
      return 1'b0;
    end
    return $urandom_range(99) < 9;
  endfunction

  // Magnitude of one two's complement axis.
  function automatic logic [sdi_pkg::FIELD_BITS-1:0] axis_size(
      input logic [sdi_pkg::FIELD_BITS-1:0] raw);
    return raw[sdi_pkg::FIELD_BITS-1] ? (~raw + 1'b1) : raw;
  endfunction

  // Floor square root of the sum of squares of three axes.
  function automatic logic [sdi_pkg::FIELD_BITS-1:0] vector_norm(
      input logic [sdi_pkg::FIELD_BITS-1:0] a,
      input logic [sdi_pkg::FIELD_BITS-1:0] b,
      input logic [sdi_pkg::FIELD_BITS-1:0] c);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] rest;
    logic [63:0] root;
    logic [63:0] probe;
    x = 64'(axis_size(a));
    y = 64'(axis_size(b));
    z = 64'(axis_size(c));
    rest = x * x + y * y + z * z;
    root = '0;
    probe = 64'd1 << 32;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[sdi_pkg::FIELD_BITS-1:0];
  endfunction

  function automatic logic [sdi_pkg::FIELD_BITS-1:0] gap_between(
      input logic [sdi_pkg::FIELD_BITS-1:0] a,
      input logic [sdi_pkg::FIELD_BITS-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Work out the reading that one accepted sample must produce.
  task automatic predict_reading(input logic [sdi_pkg::IN_DATA_BITS-1:0] d);
    reading_t                       r;
    logic [sdi_pkg::FIELD_BITS-1:0] change;
    logic [sdi_pkg::NOW_BITS-1:0]   now;
    logic [sdi_pkg::NOW_BITS-1:0]   elapsed;
    r.accel_mag = vector_norm(d[15:0], d[31:16], d[47:32]);
    r.gyro_mag  = vector_norm(d[63:48], d[79:64], d[95:80]);
    now = d[127:96];
    change = have_prev ? gap_between(r.accel_mag, prev_accel_mag) : '0;
    // The previous magnitude follows every sample, cooldown or not.
    prev_accel_mag = r.accel_mag;
    have_prev = 1'b1;
    elapsed = now - last_shake_ms;
    r.shake = 1'b0;
    if (elapsed >= sdi_pkg::NOW_BITS'(model_cfg.cooldown_ms)) begin
      if (gap_between(r.accel_mag, model_cfg.gravity_reference) >
            model_cfg.accel_deviation_threshold ||
          change > model_cfg.accel_change_threshold ||
          r.gyro_mag > model_cfg.gyro_threshold) begin
        last_shake_ms = now;
        r.shake = 1'b1;
      end
    end
    predicted_readings.push_back(r);
  endtask

  task automatic apply_register(input logic [sdi_pkg::REG_IDX_BITS-1:0] idx,
                                input logic [sdi_pkg::REG_BITS-1:0] val);
    case (idx)
      sdi_pkg::REG_GRAVITY:  model_cfg.gravity_reference = val;
      sdi_pkg::REG_DEV_THR:  model_cfg.accel_deviation_threshold = val;
      sdi_pkg::REG_CHG_THR:  model_cfg.accel_change_threshold = val;
      sdi_pkg::REG_GYRO_THR: model_cfg.gyro_threshold = val;
      sdi_pkg::REG_COOLDOWN: model_cfg.cooldown_ms = val;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("ERROR %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  // Plan entries.
  task automatic add_sample(input logic [15:0] ax, input logic [15:0] ay,
                            input logic [15:0] az, input logic [15:0] gx,
                            input logic [15:0] gy, input logic [15:0] gz,
                            input logic [31:0] now);
    plan_entry_t e;
    e = '0;
    e.kind = OP_SAMPLE;
    e.payload = {now, gz, gy, gx, az, ay, ax};
    sensor_plan.push_back(e);
  endtask

  task automatic add_config(input logic [sdi_pkg::REG_IDX_BITS-1:0] idx,
                            input logic [sdi_pkg::REG_BITS-1:0] val);
    plan_entry_t e;
    e = '0;
    e.kind = OP_CONFIG;
    e.index = idx;
    e.value = val;
    sensor_plan.push_back(e);
    case (idx)
      sdi_pkg::REG_GRAVITY:  plan_gravity = val;
      sdi_pkg::REG_DEV_THR:  plan_dev = val;
      sdi_pkg::REG_CHG_THR:  plan_chg = val;
      sdi_pkg::REG_GYRO_THR: plan_gyro = val;
      sdi_pkg::REG_COOLDOWN: plan_cool = val;
      default: ;
    endcase
  endtask

  task automatic add_drain();
    plan_entry_t e;
    e = '0;
    e.kind = OP_DRAIN;
    sensor_plan.push_back(e);
  endtask

  // Random axis value around a center, with a random sign, clipped to 16 bits.
  function automatic logic [15:0] near_value(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    if ($urandom_range(1) == 1) begin
      v = -v;
    end
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return v[15:0];
  endfunction

  // Driver: presents planned samples and performs register writes while idle.
  always @(posedge clk_i) begin : drive_proc
    logic                             accepted;
    logic                             busy;
    logic                             next_valid;
    logic [sdi_pkg::IN_DATA_BITS-1:0] next_data;
    logic                             next_we;
    logic [sdi_pkg::REG_IDX_BITS-1:0] next_index;
    logic [sdi_pkg::REG_BITS-1:0]     next_value;
    plan_entry_t                      head;
    accepted   = 1'b0;
    next_valid = s_tvalid;
    next_data  = s_tdata;
    next_we    = 1'b0;
    next_index = cfg_index;
    next_value = cfg_data;
    if (rst_ni) begin
      busy = s_tvalid || (samples_sent != readings_seen);
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (s_tvalid && s_axis_tready) begin
        predict_reading(s_tdata);
        accepted = 1'b1;
        next_valid = 1'b0;
      end
      if (!next_valid && sensor_plan.size() != 0) begin
        head = sensor_plan[0];
        case (head.kind)
          OP_SAMPLE: begin
            if (!pause_now()) begin
              next_valid = 1'b1;
              next_data = head.payload;
              void'(sensor_plan.pop_front());
            end
          end
          OP_CONFIG: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              next_we = 1'b1;
              next_index = head.index;
              next_value = head.value;
              apply_register(head.index, head.value);
              void'(sensor_plan.pop_front());
            end
          end
          default: begin
            // Hold off until every reading has come back.
            if (quiet_cycles >= SETTLE_CYCLES) begin
              void'(sensor_plan.pop_front());
            end
          end
        endcase
      end
    end
    s_tvalid  <= next_valid;
    s_tdata   <= next_data;
    cfg_we    <= next_we;
    cfg_index <= next_index;
    cfg_data  <= next_value;
    if (accepted) begin
      samples_sent <= samples_sent + 1;
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk_i) begin : watch_proc
    reading_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_tready) begin
        readings_seen <= readings_seen + 1;
        if (predicted_readings.size() == 0) begin
          report_mismatch("result with nothing expected", '0, 64'(m_axis_tdata));
        end else begin
          want = predicted_readings.pop_front();
          if (m_axis_tdata[0] !== want.shake) begin
            report_mismatch("shake", 64'(want.shake), 64'(m_axis_tdata[0]));
          end
          if (m_axis_tdata[16:1] !== want.accel_mag) begin
            report_mismatch("accel_magnitude", 64'(want.accel_mag), 64'(m_axis_tdata[16:1]));
          end
          if (m_axis_tdata[32:17] !== want.gyro_mag) begin
            report_mismatch("gyro_magnitude", 64'(want.gyro_mag), 64'(m_axis_tdata[32:17]));
          end
          if (m_axis_tdata[sdi_pkg::OUT_DATA_BITS-1:33] !== '0) begin
            report_mismatch("padding", '0,
                            64'(m_axis_tdata[sdi_pkg::OUT_DATA_BITS-1:33]));
          end
        end
      end
      m_tready <= !pause_now();
    end
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_shake_detector_imu failed");
    $finish;
  end

  // Stimulus plan, reset and end of run.
  initial begin : stimulus_proc
    logic [15:0] acc[3];
    logic [15:0] gyr[3];
    logic [15:0] value;
    logic [31:0] stamp;
    int          spread;
    int          gspread;

    // Directed part at reset values. Right after reset the last shake time is
    // zero, so early timestamps fall inside the cooldown.
    add_sample(16'd0, 16'd0, 16'd8192, 16'd0, 16'd0, 16'd0, 32'd0);
    add_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'd5);
    add_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd999);
    // Elapsed time equal to the cooldown is allowed; the change is large.
    add_sample(16'd0, 16'd0, 16'd8192, 16'd0, 16'd0, 16'd0, 32'd1000);
    add_sample(16'd0, 16'd0, -16'sd8192, 16'd0, 16'd0, 16'd26201, 32'd1500);
    // Deviation and change exactly at their thresholds, then one above.
    add_sample(16'd0, 16'd0, 16'd12288, 16'd0, 16'd0, 16'd0, 32'd2000);
    add_sample(16'd0, 16'd0, 16'd12289, 16'd0, 16'd0, 16'd0, 32'd2001);
    add_drain();
    // Inside the cooldown the previous magnitude still moves.
    add_sample(16'd0, 16'd0, 16'd8192, 16'd0, 16'd0, 16'd0, 32'd2500);
    add_sample(16'd0, 16'd0, 16'd8192, 16'd0, 16'd0, 16'd26200, 32'd4000);
    add_sample(16'd0, 16'd0, 16'd8192, 16'd0, 16'd0, -16'sd26201, 32'd4001);
    // Cooldown across the wrap of the timestamp.
    add_sample(16'd0, 16'd0, 16'd8192, 16'd0, 16'd0, 16'd30000, 32'hffff_fff0);
    add_sample(16'd0, 16'd0, 16'd8192, 16'd0, 16'd0, 16'd30000, 32'h0000_0100);
    add_sample(16'd0, 16'd0, 16'd8192, 16'd0, 16'd0, 16'd30000, 32'h0000_03d8);
    // Thresholds at the top, no cooldown, gravity at zero.
    add_config(sdi_pkg::REG_COOLDOWN, 16'd0);
    add_config(sdi_pkg::REG_DEV_THR, 16'hffff);
    add_config(sdi_pkg::REG_CHG_THR, 16'hffff);
    add_config(sdi_pkg::REG_GYRO_THR, 16'hffff);
    add_config(sdi_pkg::REG_GRAVITY, 16'd0);
    add_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 32'd985);
    // Thresholds at zero, gravity at the top.
    add_config(sdi_pkg::REG_GRAVITY, 16'hffff);
    add_config(sdi_pkg::REG_DEV_THR, 16'd0);
    add_config(sdi_pkg::REG_CHG_THR, 16'd0);
    add_config(sdi_pkg::REG_GYRO_THR, 16'd0);
    add_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd985);
    add_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd985);
    // Only the change or only the gyro can fire.
    add_config(sdi_pkg::REG_GRAVITY, 16'd0);
    add_config(sdi_pkg::REG_DEV_THR, 16'hffff);
    add_sample(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd986);
    add_config(sdi_pkg::REG_CHG_THR, 16'hffff);
    add_sample(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 32'd987);
    // Writes to unused indexes must change nothing.
    for (int i = REG_COUNT; i < (1 << sdi_pkg::REG_IDX_BITS); i++) begin
      add_config(sdi_pkg::REG_IDX_BITS'(i), 16'($urandom));
    end
    add_sample(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd988);
    add_config(sdi_pkg::REG_GRAVITY, sdi_pkg::GRAVITY_RST);
    add_config(sdi_pkg::REG_DEV_THR, sdi_pkg::DEV_THR_RST);
    add_config(sdi_pkg::REG_CHG_THR, sdi_pkg::CHG_THR_RST);
    add_config(sdi_pkg::REG_GYRO_THR, sdi_pkg::GYRO_THR_RST);
    add_config(sdi_pkg::REG_COOLDOWN, sdi_pkg::COOLDOWN_RST);

    // Random phases, each with its own register setting.
    stamp = 32'd5000;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int r = 0; r < REG_COUNT; r++) begin
        case ($urandom_range(9))
          0, 1: begin
            case (r)
              sdi_pkg::REG_GRAVITY:  value = sdi_pkg::GRAVITY_RST;
              sdi_pkg::REG_DEV_THR:  value = sdi_pkg::DEV_THR_RST;
              sdi_pkg::REG_CHG_THR:  value = sdi_pkg::CHG_THR_RST;
              sdi_pkg::REG_GYRO_THR: value = sdi_pkg::GYRO_THR_RST;
              default:               value = sdi_pkg::COOLDOWN_RST;
            endcase
          end
          2: value = '0;
          3: value = '1;
          4: value = 16'($urandom);
          default: begin
            case (r)
              sdi_pkg::REG_GRAVITY:  value = 16'($urandom_range(20000, 4000));
              sdi_pkg::REG_DEV_THR,
              sdi_pkg::REG_CHG_THR:  value = 16'($urandom_range(8000));
              sdi_pkg::REG_GYRO_THR: value = 16'($urandom_range(40000));
              default:               value = 16'($urandom_range(3000));
            endcase
          end
        endcase
        add_config(sdi_pkg::REG_IDX_BITS'(r), value);
      end
      if ($urandom_range(3) == 0) begin
        add_config(sdi_pkg::REG_IDX_BITS'($urandom_range((1 << sdi_pkg::REG_IDX_BITS) - 1,
                                                         REG_COUNT)),
                   16'($urandom));
      end
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        if (n == PHASE_SAMPLES / 2 && $urandom_range(2) == 0) begin
          add_drain();
        end
        if ($urandom_range(3) == 0) begin
          // Noise: any value on every axis.
          for (int a = 0; a < 3; a++) begin
            acc[a] = 16'($urandom);
            gyr[a] = 16'($urandom);
          end
        end else begin
          // Device at rest or moving: one axis near gravity, the rest small.
          case ($urandom_range(3))
            0: spread = 32;
            1: spread = plan_dev / 2 + 8;
            2: spread = plan_dev + plan_chg + 8;
            default: spread = 12000;
          endcase
          case ($urandom_range(3))
            0: gspread = 100;
            1: gspread = plan_gyro / 2 + 8;
            2: gspread = plan_gyro + 8;
            default: gspread = 32767;
          endcase
          for (int a = 0; a < 3; a++) begin
            acc[a] = near_value(0, spread / 4);
            gyr[a] = near_value(0, gspread);
          end
          acc[$urandom_range(2)] = near_value(plan_gravity, spread);
        end
        // Timestamps mostly advance on the scale of the cooldown.
        case ($urandom_range(9))
          0: stamp = $urandom;
          1, 2: stamp = stamp + $urandom_range(40);
          3: stamp = stamp + plan_cool;
          default: stamp = stamp + $urandom_range(2 * plan_cool + 2);
        endcase
        add_sample(acc[0], acc[1], acc[2], gyr[0], gyr[1], gyr[2], stamp);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sensor_plan.size() != 0 || s_tvalid || samples_sent != readings_seen) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (predicted_readings.size() != 0) begin
      report_mismatch("readings never delivered", 64'(predicted_readings.size()), '0);
    end
    if (mismatches == 0) begin
      $display("tb_shake_detector_imu passed");
    end else begin
      $display("tb_shake_detector_imu failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/sdi_pkg.sv
sv/sdi_mag_lane.sv
sv/sdi_decide.sv
sv/shake_detector_imu.sv
sim/tb_shake_detector_imu.sv
